### rtl/core/ekct_pkg.sv
// Shared types, key codes and escape-sequence decode tables for the
// escape key cursor tracker. No dependencies; every other file imports it.

package ekct_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	typedef logic [8:0] key_t;

	// Terminal bytes of interest
	localparam logic [7:0] CH_ESC       = 8'h1b;
	localparam logic [7:0] CH_LBRACKET  = 8'h5b;
	localparam logic [7:0] CH_SS3       = 8'h4f;
	localparam logic [7:0] CH_TILDE     = 8'h7e;
	localparam logic [7:0] CH_Q         = 8'h71;
	localparam logic [7:0] CTRL_MASK    = 8'h1f;
	localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
	localparam logic [7:0] CH_DIGIT_HI  = 8'h39;

	localparam key_t KEY_ESC   = {1'b0, CH_ESC};
	localparam key_t KEY_QUIT  = {1'b0, CH_Q & CTRL_MASK};
	localparam key_t KEY_LEFT  = 9'd256;
	localparam key_t KEY_RIGHT = 9'd257;
	localparam key_t KEY_UP    = 9'd258;
	localparam key_t KEY_DOWN  = 9'd259;
	localparam key_t KEY_DEL   = 9'd260;
	localparam key_t KEY_HOME  = 9'd261;
	localparam key_t KEY_END   = 9'd262;
	localparam key_t KEY_PGUP  = 9'd263;
	localparam key_t KEY_PGDN  = 9'd264;

	// Decoder phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ESC   = 2'd1;
	localparam logic [1:0] PH_SEQ0  = 2'd2;
	localparam logic [1:0] PH_DIGIT = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_ROWS   = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		key_t        key_code;
		logic        quit_request;
		logic [15:0] cursor_col;
		logic [15:0] cursor_row;
		logic [15:0] row_offset;
		logic [15:0] col_offset;
	} out_item_t;

	typedef struct packed {
		logic valid;
		key_t key;
	} key_xfer_t;

	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	function automatic key_t decode_pair(input logic [7:0] s0, input logic [7:0] s1);
		key_t k;
		k = KEY_ESC;
		if (s0 == CH_LBRACKET) begin
			unique case (s1)
				8'h41:   k = KEY_UP;
				8'h42:   k = KEY_DOWN;
				8'h43:   k = KEY_RIGHT;
				8'h44:   k = KEY_LEFT;
				8'h48:   k = KEY_HOME;
				8'h46:   k = KEY_END;
				default: k = KEY_ESC;
			endcase
		end else if (s0 == CH_SS3) begin
			if (s1 == 8'h48) k = KEY_HOME;
			else if (s1 == 8'h46) k = KEY_END;
		end
		return k;
	endfunction

	function automatic key_t decode_tilde(input logic [7:0] d);
		key_t k;
		unique case (d)
			8'h31, 8'h37: k = KEY_HOME;
			8'h33:        k = KEY_DEL;
			8'h34, 8'h38: k = KEY_END;
			8'h35:        k = KEY_PGUP;
			8'h36:        k = KEY_PGDN;
			default:      k = KEY_ESC;
		endcase
		return k;
	endfunction

endpackage

### rtl/core/ekct_front.sv
// Front end: accepts terminal bytes and timeout ticks and runs the escape
// sequence state machine. Depends on ekct_pkg; feeds ekct_queue.

module ekct_front import ekct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in,
	input  logic      push,
	input  logic      room,
	output logic      full,
	output key_xfer_t kx
);

	logic [1:0] phase_q, phase_nx;
	logic [7:0] first_q, first_nx;
	logic [7:0] pending_q, pending_nx;
	logic       accept;
	logic       is_digit;

	assign full     = !room;
	assign accept   = push && room;
	assign is_digit = (in.in_byte >= CH_DIGIT_LO) && (in.in_byte <= CH_DIGIT_HI);

	always_comb begin
		phase_nx   = phase_q;
		first_nx   = first_q;
		pending_nx = pending_q;
		kx.valid   = 1'b0;
		kx.key     = KEY_ESC;
		if (accept) begin
			if (in.req_type) begin
				// A timeout only matters in the middle of a sequence.
				if (phase_q != PH_IDLE) begin
					kx.valid = 1'b1;
					phase_nx = PH_IDLE;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (in.in_byte == CH_ESC) begin
							phase_nx = PH_ESC;
						end else begin
							kx.valid = 1'b1;
							kx.key   = {1'b0, in.in_byte};
						end
					end
					PH_ESC: begin
						first_nx = in.in_byte;
						phase_nx = PH_SEQ0;
					end
					PH_SEQ0: begin
						pending_nx = in.in_byte;
						if (first_q == CH_LBRACKET && is_digit) begin
							phase_nx = PH_DIGIT;
						end else begin
							phase_nx = PH_IDLE;
							kx.valid = 1'b1;
							kx.key   = decode_pair(first_q, in.in_byte);
						end
					end
					PH_DIGIT: begin
						phase_nx = PH_IDLE;
						kx.valid = 1'b1;
						kx.key   = (in.in_byte == CH_TILDE) ? decode_tilde(pending_q) : KEY_ESC;
					end
					default: phase_nx = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			first_q   <= '0;
			pending_q <= '0;
		end else begin
			phase_q   <= phase_nx;
			first_q   <= first_nx;
			pending_q <= pending_nx;
		end
	end

endmodule

### rtl/core/ekct_queue.sv
// Short key queue between the decoder front end and the cursor back end.
// Depends on ekct_pkg for the key transfer type and the queue depth.

module ekct_queue import ekct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  key_xfer_t kx,
	input  logic      pop,
	output key_t      head,
	output logic      empty,
	output logic      room
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	key_t             store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign empty = (count_q == '0);
	assign room  = (count_q != FULL_CNT);
	assign head  = store_q[rd_ptr_q];
	assign do_wr = kx.valid;
	assign do_rd = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) store_q[wr_ptr_q] <= kx.key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/core/ekct_back.sv
// Back end: configuration registers, cursor update stage and scroll/output
// stage. Depends on ekct_pkg; takes keys from ekct_queue.

module ekct_back import ekct_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg,
	input  logic      q_empty,
	input  key_t      q_key,
	output logic      q_pop,
	output out_item_t res,
	output logic      empty,
	input  logic      pop
);

	// Wide enough for the file row count and for a position plus a screen size.
	localparam int EW = (POS_WIDTH > 16 ? POS_WIDTH : 16) + 1;
	typedef logic [EW-1:0] ext_t;
	localparam ext_t POS_MAX = {{(EW - POS_WIDTH){1'b0}}, {POS_WIDTH{1'b1}}};
	localparam ext_t ONE     = ext_t'(1);

	logic [9:0]           screen_rows_q, screen_cols_q;
	logic [15:0]          file_rows_q;
	logic [POS_WIDTH-1:0] col_q, row_q, top_q, left_q;
	key_t                 key_s1;
	logic                 valid_s1;
	out_item_t            out_q;
	logic                 out_valid_q;

	ext_t sr, sc, fr_raw, fr, row_e, col_e, top_e, left_e;
	ext_t row_nx, col_nx, row_sum, end_col;
	ext_t top1, top2, left1, left2;
	logic adv;

	assign adv   = !out_valid_q || pop;
	assign q_pop = adv && !q_empty;
	assign empty = !out_valid_q;
	assign res   = out_q;

	always_comb begin
		sr      = ext_t'((screen_rows_q == '0) ? 10'd1 : screen_rows_q);
		sc      = ext_t'((screen_cols_q == '0) ? 10'd1 : screen_cols_q);
		fr_raw  = ext_t'(file_rows_q);
		fr      = (fr_raw > POS_MAX) ? POS_MAX : fr_raw;
		row_e   = ext_t'(row_q);
		col_e   = ext_t'(col_q);
		top_e   = ext_t'(top_q);
		left_e  = ext_t'(left_q);
		row_sum = row_e + sr;
		end_col = ((sc - ONE) > POS_MAX) ? POS_MAX : (sc - ONE);

		row_nx = row_e;
		col_nx = col_e;
		unique case (q_key)
			KEY_LEFT:  if (col_e != '0) col_nx = col_e - ONE;
			KEY_RIGHT: if (col_e < POS_MAX) col_nx = col_e + ONE;
			KEY_UP:    if (row_e != '0) row_nx = row_e - ONE;
			KEY_DOWN:  if (row_e < fr) row_nx = row_e + ONE;
			KEY_PGUP:  row_nx = (row_e >= sr) ? row_e - sr : '0;
			KEY_PGDN:  if (row_e < fr) row_nx = (row_sum > fr) ? fr : row_sum;
			KEY_HOME:  col_nx = '0;
			KEY_END:   col_nx = end_col;
			default:   ;
		endcase

		// Scrolling works on the position left by the key in stage one.
		top1  = (row_e < top_e) ? row_e : top_e;
		top2  = (row_e >= top1 + sr) ? row_e - sr + ONE : top1;
		left1 = (col_e < left_e) ? col_e : left_e;
		left2 = (col_e >= left1 + sc) ? col_e - sc + ONE : left1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_rows_q <= 10'd24;
			screen_cols_q <= 10'd80;
			file_rows_q   <= '0;
			col_q         <= '0;
			row_q         <= '0;
			top_q         <= '0;
			left_q        <= '0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_SCREEN_ROWS: screen_rows_q <= cfg.data[9:0];
					CFG_SCREEN_COLS: screen_cols_q <= cfg.data[9:0];
					CFG_FILE_ROWS:   file_rows_q   <= cfg.data;
					default:         ;
				endcase
			end
			if (adv) begin
				valid_s1    <= !q_empty;
				out_valid_q <= valid_s1;
				if (!q_empty) begin
					row_q <= row_nx[POS_WIDTH-1:0];
					col_q <= col_nx[POS_WIDTH-1:0];
				end
				if (valid_s1) begin
					top_q  <= top2[POS_WIDTH-1:0];
					left_q <= left2[POS_WIDTH-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) key_s1 <= q_key;
		if (adv && valid_s1) begin
			out_q.key_code     <= key_s1;
			out_q.quit_request <= (key_s1 == KEY_QUIT);
			out_q.cursor_col   <= col_e[15:0];
			out_q.cursor_row   <= row_e[15:0];
			out_q.row_offset   <= top2[15:0];
			out_q.col_offset   <= left2[15:0];
		end
	end

endmodule

### rtl/core/escape_key_cursor_tracker.sv
// Top level of the escape key cursor tracker: decoder front end, key queue
// and cursor back end. Depends on ekct_pkg, ekct_front, ekct_queue, ekct_back.
//
//   channel   handshake            payload
//   input     push / full          in  (req_type, in_byte)
//   result    empty / pop          res (key, quit flag, cursor, offsets)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle while full is low; a key reaches the result
// ports through the queue, the cursor stage and the scroll stage.
// Reset clears the decoder, the queue and the cursor state at once; no
// clearing pass is needed. When results are not taken the back end holds,
// the four-entry queue fills and full rises. Configuration is always ready.

module escape_key_cursor_tracker import ekct_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in,
	input  logic                  push,
	output logic                  full,
	output out_item_t             res,
	output logic                  empty,
	input  logic                  pop,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	key_xfer_t kx;
	key_t      q_key;
	logic      q_empty, q_room, q_pop;
	cfg_wr_t   cfg;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	ekct_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in),
		.push   (push),
		.room   (q_room),
		.full   (full),
		.kx     (kx)
	);

	ekct_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.kx     (kx),
		.pop    (q_pop),
		.head   (q_key),
		.empty  (q_empty),
		.room   (q_room)
	);

	ekct_back #(
		.POS_WIDTH (POS_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_key   (q_key),
		.q_pop   (q_pop),
		.res     (res),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

### rtl/core/ekct_checker.sv
// Port-level checks on the result channel of the escape key cursor tracker,
// bound to the top level. Depends on ekct_pkg and escape_key_cursor_tracker.

module ekct_checker import ekct_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input out_item_t res,
	input logic      empty,
	input logic      pop
);

	// A waiting result must not change until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(res))
		else $error("result changed while waiting");

	a_quit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (res.quit_request == (res.key_code == KEY_QUIT)))
		else $error("quit flag does not match key");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (res.key_code <= KEY_PGDN))
		else $error("key code out of range");

	a_home: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (res.key_code == KEY_HOME) |-> (res.cursor_col == '0) && (res.col_offset == '0))
		else $error("home key left the cursor away from column zero");

endmodule

bind escape_key_cursor_tracker ekct_checker u_ekct_checker (.*);
